// ===== sv/wav_stream_mono_dac_feeder_macros.svh =====
// Assertion helpers for the WAV byte-stream feeder.
// Both expect clk and rst_n in scope at the point of use.
`ifndef WAV_STREAM_MONO_DAC_FEEDER_MACROS_SVH
`define WAV_STREAM_MONO_DAC_FEEDER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define WSDF_ASSERT_NOW(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("wav feeder check failed");

// Next-cycle implication, checked outside reset
`define WSDF_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("wav feeder check failed");

`endif

// ===== sv/wsdf_pkg.sv =====
`timescale 1ns / 1ps

package wsdf_pkg;

    // Default channel limit for the mono downmix
    localparam int MAX_CHANNELS_DEF = 8;

    // Bytes of the fmt body that carry fields
    localparam int FORMAT_BYTES = 16;
    localparam int FMT_IDX_W    = $clog2(FORMAT_BYTES);

    // Byte positions inside the fmt body
    localparam logic [FMT_IDX_W-1:0] FMT_CH_LO    = FMT_IDX_W'(2);
    localparam logic [FMT_IDX_W-1:0] FMT_CH_HI    = FMT_IDX_W'(3);
    localparam logic [FMT_IDX_W-1:0] FMT_BLOCK_LO = FMT_IDX_W'(12);
    localparam logic [FMT_IDX_W-1:0] FMT_BLOCK_HI = FMT_IDX_W'(13);
    localparam logic [FMT_IDX_W-1:0] FMT_BITS_LO  = FMT_IDX_W'(14);
    localparam logic [FMT_IDX_W-1:0] FMT_BITS_HI  = FMT_IDX_W'(15);
    localparam logic [FMT_IDX_W-1:0] FMT_LAST     = FMT_IDX_W'(FORMAT_BYTES - 1);

    // Chunk tags, little-endian ASCII
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_LIST = 32'h5453_494c;

    // Sample conversion
    localparam logic [15:0] SAMPLE_BITS_16 = 16'd16;
    localparam logic [15:0] SAMPLE_OFFSET  = 16'h8000;
    localparam logic [15:0] CODE_MASK      = 16'hFFC0;

    // Shared divider
    localparam int DIV_BITS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

    // Result status codes
    localparam logic [1:0] STATUS_SAMPLE = 2'd0;
    localparam logic [1:0] STATUS_END    = 2'd1;
    localparam logic [1:0] STATUS_TRUNC  = 2'd2;
    localparam logic [1:0] STATUS_BAD_CH = 2'd3;

    // Parse phase
    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_RIFF   = 5'b00010,
        PH_FMT    = 5'b00100,
        PH_SKIP   = 5'b01000,
        PH_SLICE  = 5'b10000
    } phase_t;

    // Sequencer around the shared divider
    typedef enum logic [2:0] {
        SEQ_IDLE    = 3'b001,
        SEQ_DIV_LEN = 3'b010,
        SEQ_DIV_AVG = 3'b100
    } seq_t;

endpackage

// ===== sv/wav_stream_mono_dac_feeder.sv =====
// Channel | Handshake             | Payload
// --------+-----------------------+---------------------------
// in      | in_valid / in_stall   | file_byte[7:0], end_of_file
// out     | out_valid / out_stall | dac_code[15:0], status[1:0]
//
// The last header byte of a data chunk with a nonzero block size and the last
// byte of a 16-bit slice start the shared restoring divider: a load, 32
// iterations (one quotient bit a cycle) and a finishing step.
// Reset is asynchronous and clears all parse state at once; no clearing pass.
// in_stall is high while the divider runs and while a result waits under
// out_stall; results sit in an output register until taken.
`timescale 1ns / 1ps
`include "wav_stream_mono_dac_feeder_macros.svh"

module wav_stream_mono_dac_feeder #(
    parameter int MAX_CHANNELS = wsdf_pkg::MAX_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] dac_code,
    output logic [1:0]  status
);

    localparam int SUM_W = 16 + $clog2(MAX_CHANNELS);
    localparam logic [15:0] MAX_CH16 = 16'(MAX_CHANNELS);
    localparam int CNT_W = wsdf_pkg::DIV_CNT_W;
    localparam int IDX_W = wsdf_pkg::FMT_IDX_W;

    wsdf_pkg::seq_t   state_reg, state_next;
    wsdf_pkg::phase_t phase_reg, phase_next;

    logic [2:0]              hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]             tag_reg, tag_next;
    logic [31:0]             len_reg, len_next;
    logic [31:0]             skip_reg, skip_next;
    logic [IDX_W-1:0]        fmt_idx_reg, fmt_idx_next;
    logic [15:0]             ch_reg, ch_next;
    logic [15:0]             bits_reg, bits_next;
    logic [15:0]             block_reg, block_next;
    logic [31:0]             slices_reg, slices_next;
    logic [15:0]             sidx_reg, sidx_next;
    logic [7:0]              low_reg, low_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    done_reg, done_next;

    // Shared divider registers
    logic [15:0]      rem_reg, rem_next;
    logic [31:0]      dq_reg, dq_next;
    logic [15:0]      dvs_reg, dvs_next;
    logic [CNT_W-1:0] dcnt_reg, dcnt_next;
    logic             neg_reg, neg_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] dac_code_reg, dac_code_next;
    logic [1:0]  status_reg, status_next;

    logic                    accept;
    logic                    out_free;
    logic [31:0]             full_len;
    logic [2:0]              riff_cnt;
    logic [31:0]             skip_dec;
    logic                    acc_en;
    logic signed [15:0]      sample;
    logic signed [SUM_W-1:0] slice_sum;
    logic [SUM_W-1:0]        sum_mag;
    logic [31:0]             slices_dec;
    logic                    bad_ch;
    logic [17:0]             trial;
    logic [16:0]             quot;
    logic [16:0]             avg;
    logic                    res_load;
    logic [15:0]             res_code;
    logic [1:0]              res_status;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != wsdf_pkg::SEQ_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign dac_code  = dac_code_reg;
    assign status    = status_reg;

    // Per-byte datapath values
    assign full_len   = {file_byte, len_reg[23:0]};
    assign riff_cnt   = hdr_cnt_reg + 3'd1;
    assign skip_dec   = (skip_reg != 32'd0) ? skip_reg - 32'd1 : 32'd0;
    assign acc_en     = (bits_reg == wsdf_pkg::SAMPLE_BITS_16) && (ch_reg <= MAX_CH16)
                        && ({1'b0, sidx_reg} < {ch_reg, 1'b0});
    assign sample     = $signed({file_byte, low_reg});
    assign slice_sum  = (acc_en && sidx_reg[0]) ? sum_reg + SUM_W'(sample) : sum_reg;
    assign sum_mag    = slice_sum[SUM_W-1] ? SUM_W'(-slice_sum) : SUM_W'(slice_sum);
    assign slices_dec = (slices_reg != 32'd0) ? slices_reg - 32'd1 : 32'd0;
    assign bad_ch     = (ch_reg == 16'd0) || (ch_reg > MAX_CH16);

    // One restoring step of the divider
    assign trial = {1'b0, rem_reg, dq_reg[31]} - {2'b00, dvs_reg};
    assign quot  = dq_reg[16:0];
    assign avg   = neg_reg ? 17'(-quot) : quot;

    // Sequencer and parser
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        skip_next     = skip_reg;
        fmt_idx_next  = fmt_idx_reg;
        ch_next       = ch_reg;
        bits_next     = bits_reg;
        block_next    = block_reg;
        slices_next   = slices_reg;
        sidx_next     = sidx_reg;
        low_next      = low_reg;
        sum_next      = sum_reg;
        done_next     = done_reg;
        rem_next      = rem_reg;
        dq_next       = dq_reg;
        dvs_next      = dvs_reg;
        dcnt_next     = dcnt_reg;
        neg_next      = neg_reg;
        res_load      = 1'b0;
        res_code      = 16'd0;
        res_status    = wsdf_pkg::STATUS_SAMPLE;

        case (state_reg)
            wsdf_pkg::SEQ_IDLE:
            begin
                if (accept && !done_reg) begin
                    if (end_of_file) begin
                        // Close the stream
                        done_next  = 1'b1;
                        res_load   = 1'b1;
                        res_status = (phase_reg == wsdf_pkg::PH_SLICE) ?
                                     wsdf_pkg::STATUS_TRUNC : wsdf_pkg::STATUS_END;
                    end else begin
                        case (phase_reg)
                            wsdf_pkg::PH_HEADER:
                            begin
                                // Collect tag and length, then dispatch
                                if (!hdr_cnt_reg[2])
                                    tag_next[{hdr_cnt_reg[1:0], 3'b000} +: 8] = file_byte;
                                else
                                    len_next[{hdr_cnt_reg[1:0], 3'b000} +: 8] = file_byte;
                                hdr_cnt_next = hdr_cnt_reg + 3'd1;
                                if (hdr_cnt_reg == 3'd7) begin
                                    if (tag_reg == wsdf_pkg::TAG_RIFF) begin
                                        hdr_cnt_next = 3'd0;
                                        phase_next   = wsdf_pkg::PH_RIFF;
                                    end else if (tag_reg == wsdf_pkg::TAG_FMT) begin
                                        fmt_idx_next = '0;
                                        skip_next    = (full_len > 32'(wsdf_pkg::FORMAT_BYTES)) ?
                                            full_len - 32'(wsdf_pkg::FORMAT_BYTES) : 32'd0;
                                        phase_next   = wsdf_pkg::PH_FMT;
                                    end else if (tag_reg == wsdf_pkg::TAG_DATA
                                                 && block_reg != 16'd0) begin
                                        // Count slices on the shared divider
                                        sidx_next  = 16'd0;
                                        sum_next   = '0;
                                        rem_next   = 16'd0;
                                        dq_next    = full_len;
                                        dvs_next   = block_reg;
                                        dcnt_next  = CNT_W'(wsdf_pkg::DIV_BITS);
                                        state_next = wsdf_pkg::SEQ_DIV_LEN;
                                    end else begin
                                        // LIST, unknown, or data with no block size
                                        skip_next  = full_len;
                                        phase_next = (full_len != 32'd0) ?
                                                     wsdf_pkg::PH_SKIP : wsdf_pkg::PH_HEADER;
                                    end
                                end
                            end
                            wsdf_pkg::PH_RIFF:
                            begin
                                // Drop the form type
                                hdr_cnt_next = riff_cnt;
                                if (riff_cnt >= 3'd4) begin
                                    hdr_cnt_next = 3'd0;
                                    phase_next   = wsdf_pkg::PH_HEADER;
                                end
                            end
                            wsdf_pkg::PH_FMT:
                            begin
                                // Capture format fields
                                case (fmt_idx_reg)
                                    wsdf_pkg::FMT_CH_LO:    ch_next[7:0]     = file_byte;
                                    wsdf_pkg::FMT_CH_HI:    ch_next[15:8]    = file_byte;
                                    wsdf_pkg::FMT_BLOCK_LO: block_next[7:0]  = file_byte;
                                    wsdf_pkg::FMT_BLOCK_HI: block_next[15:8] = file_byte;
                                    wsdf_pkg::FMT_BITS_LO:  bits_next[7:0]   = file_byte;
                                    wsdf_pkg::FMT_BITS_HI:  bits_next[15:8]  = file_byte;
                                    default: ;
                                endcase
                                fmt_idx_next = fmt_idx_reg + 1'b1;
                                if (fmt_idx_reg == wsdf_pkg::FMT_LAST) begin
                                    fmt_idx_next = '0;
                                    phase_next   = (skip_reg != 32'd0) ?
                                                   wsdf_pkg::PH_SKIP : wsdf_pkg::PH_HEADER;
                                end
                            end
                            wsdf_pkg::PH_SKIP:
                            begin
                                skip_next = skip_dec;
                                if (skip_dec == 32'd0)
                                    phase_next = wsdf_pkg::PH_HEADER;
                            end
                            wsdf_pkg::PH_SLICE:
                            begin
                                // Gather channel samples
                                if (acc_en && !sidx_reg[0])
                                    low_next = file_byte;
                                sum_next = slice_sum;
                                if ({1'b0, sidx_reg} + 17'd1 < {1'b0, block_reg}) begin
                                    sidx_next = sidx_reg + 16'd1;
                                end else begin
                                    sidx_next = 16'd0;
                                    if (bad_ch) begin
                                        done_next  = 1'b1;
                                        res_load   = 1'b1;
                                        res_status = wsdf_pkg::STATUS_BAD_CH;
                                    end else begin
                                        sum_next    = '0;
                                        slices_next = slices_dec;
                                        if (slices_dec == 32'd0)
                                            phase_next = wsdf_pkg::PH_HEADER;
                                        if (bits_reg == wsdf_pkg::SAMPLE_BITS_16) begin
                                            // Average on the shared divider
                                            rem_next   = 16'd0;
                                            dq_next    = 32'(sum_mag);
                                            dvs_next   = ch_reg;
                                            neg_next   = slice_sum[SUM_W-1];
                                            dcnt_next  = CNT_W'(wsdf_pkg::DIV_BITS);
                                            state_next = wsdf_pkg::SEQ_DIV_AVG;
                                        end else begin
                                            res_load = 1'b1;
                                        end
                                    end
                                end
                            end
                            default:
                            begin
                                phase_next = wsdf_pkg::PH_HEADER;
                            end
                        endcase
                    end
                end
            end
            wsdf_pkg::SEQ_DIV_LEN,
            wsdf_pkg::SEQ_DIV_AVG:
            begin
                if (dcnt_reg != '0) begin
                    // Advance one quotient bit
                    if (!trial[17]) begin
                        rem_next = trial[15:0];
                        dq_next  = {dq_reg[30:0], 1'b1};
                    end else begin
                        rem_next = {rem_reg[14:0], dq_reg[31]};
                        dq_next  = {dq_reg[30:0], 1'b0};
                    end
                    dcnt_next = dcnt_reg - 1'b1;
                end else if (state_reg == wsdf_pkg::SEQ_DIV_LEN) begin
                    slices_next = dq_reg;
                    phase_next  = (dq_reg != 32'd0) ?
                                  wsdf_pkg::PH_SLICE : wsdf_pkg::PH_HEADER;
                    state_next  = wsdf_pkg::SEQ_IDLE;
                end else if (out_free) begin
                    // Offset, mask and deliver the mono code
                    res_load   = 1'b1;
                    res_code   = 16'(avg[15:0] + wsdf_pkg::SAMPLE_OFFSET)
                                 & wsdf_pkg::CODE_MASK;
                    state_next = wsdf_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = wsdf_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Load or drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        dac_code_next  = dac_code_reg;
        status_next    = status_reg;
        if (res_load) begin
            out_valid_next = 1'b1;
            dac_code_next  = res_code;
            status_next    = res_status;
        end else if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= wsdf_pkg::SEQ_IDLE;
            phase_reg     <= wsdf_pkg::PH_HEADER;
            hdr_cnt_reg   <= 3'd0;
            tag_reg       <= 32'd0;
            len_reg       <= 32'd0;
            skip_reg      <= 32'd0;
            fmt_idx_reg   <= '0;
            ch_reg        <= 16'd0;
            bits_reg      <= 16'd0;
            block_reg     <= 16'd0;
            slices_reg    <= 32'd0;
            sidx_reg      <= 16'd0;
            low_reg       <= 8'd0;
            sum_reg       <= '0;
            done_reg      <= 1'b0;
            rem_reg       <= 16'd0;
            dq_reg        <= 32'd0;
            dvs_reg       <= 16'd0;
            dcnt_reg      <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            dac_code_reg  <= 16'd0;
            status_reg    <= wsdf_pkg::STATUS_SAMPLE;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            tag_reg       <= tag_next;
            len_reg       <= len_next;
            skip_reg      <= skip_next;
            fmt_idx_reg   <= fmt_idx_next;
            ch_reg        <= ch_next;
            bits_reg      <= bits_next;
            block_reg     <= block_next;
            slices_reg    <= slices_next;
            sidx_reg      <= sidx_next;
            low_reg       <= low_next;
            sum_reg       <= sum_next;
            done_reg      <= done_next;
            rem_reg       <= rem_next;
            dq_reg        <= dq_next;
            dvs_reg       <= dvs_next;
            dcnt_reg      <= dcnt_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
            dac_code_reg  <= dac_code_next;
            status_reg    <= status_next;
        end
    end

    // Checks
    `WSDF_ASSERT_NOW(a_rem_below_divisor, state_reg != wsdf_pkg::SEQ_IDLE, rem_reg < dvs_reg)
    `WSDF_ASSERT_NOW(a_slice_has_count, phase_reg == wsdf_pkg::PH_SLICE, slices_reg != 32'd0)
    `WSDF_ASSERT_NOW(a_code_only_sample, out_valid_reg && status_reg != wsdf_pkg::STATUS_SAMPLE, dac_code_reg == 16'd0)
    `WSDF_ASSERT_NEXT(a_eof_gives_result, accept && end_of_file && !done_reg, out_valid_reg)
    `WSDF_ASSERT_NEXT(a_quiet_after_done, done_reg && !out_valid_reg, !out_valid_reg)

endmodule
